// File: src/tte_pkg.sv
// Shared types and constants for the tap tempo estimator core.
// No dependencies; imported by the controller, datapath and top level.
package tte_pkg;

   localparam int CountWidth = 16;
   localparam int KnobWidth  = 12;
   localparam int FreqWidth  = 24;
   localparam int CfgWidth   = 16;
   localparam int DivSteps   = 32;
   localparam int StepWidth  = $clog2(DivSteps);

   localparam logic [FreqWidth-1:0] FreqMax = '1;
   localparam logic [7:0] WeightOld = 8'd154;
   localparam logic [7:0] WeightNew = 8'd102;

   localparam logic [CfgWidth-1:0]  ResetBlocksPerSecond = 16'd12000;
   localparam logic [CfgWidth-1:0]  ResetMinCount        = 16'd343;
   localparam logic [CfgWidth-1:0]  ResetMaxCount        = 16'd36036;
   localparam logic [KnobWidth-1:0] ResetKnobDeadband    = 12'd205;

   typedef enum logic [1:0] {
      CSR_BLOCKS_PER_SECOND = 2'd0,
      CSR_MIN_COUNT         = 2'd1,
      CSR_MAX_COUNT         = 2'd2,
      CSR_KNOB_DEADBAND     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
   } status_type;

endpackage

// File: src/tte_ctrl.sv
// Sequencer for the tap tempo estimator: accept, evaluate, divide, commit.
// Depends on tte_pkg.
module tte_ctrl import tte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type             state_ff, state_in;
   logic [StepWidth-1:0]  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            step_in = '0;
            if (status.need_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == StepWidth'(DivSteps - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: src/tte_datapath.sv
// Datapath: settings, tempo state, restoring divider, blend and result register.
// Depends on tte_pkg.
module tte_datapath import tte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [CfgWidth-1:0]  csr_wdata,
   input  logic [15:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   input  cmd_type              cmd,
   output status_type           status
);

   logic [CfgWidth-1:0]   bps_ff, min_ff, max_ff;
   logic [KnobWidth-1:0]  deadband_ff;

   logic [CountWidth-1:0] tick_ff, tick_in;
   logic                  tapping_ff, tapping_in;
   logic                  averaging_ff, averaging_in;
   logic                  mode_ff, mode_in;
   logic [FreqWidth-1:0]  freq_ff, freq_in;
   logic [KnobWidth-1:0]  last_knob_ff, last_knob_in;

   logic                  tap_ff;
   logic [KnobWidth-1:0]  knob_ff;
   logic [CountWidth-1:0] cnt_ff;

   logic [CountWidth:0]   rem_ff;
   logic [31:0]           quo_ff;

   logic                  rsp_valid_ff;
   logic [31:0]           rsp_data_ff;

   logic [CountWidth:0]   rem_shift;
   logic                  q_bit;
   logic                  accept;
   logic [FreqWidth-1:0]  new_freq;
   logic [31:0]           mix;
   logic [KnobWidth:0]    diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff      <= ResetBlocksPerSecond;
         min_ff      <= ResetMinCount;
         max_ff      <= ResetMaxCount;
         deadband_ff <= ResetKnobDeadband;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_BLOCKS_PER_SECOND: bps_ff      <= csr_wdata;
            CSR_MIN_COUNT:         min_ff      <= csr_wdata;
            CSR_MAX_COUNT:         max_ff      <= csr_wdata;
            CSR_KNOB_DEADBAND:     deadband_ff <= csr_wdata[KnobWidth-1:0];
            default: ;
         endcase
      end
   end

   // input latch and divider
   assign rem_shift = {rem_ff[CountWidth-1:0], quo_ff[31]};
   assign q_bit     = rem_shift >= {1'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tap_ff  <= req_tdata[0];
         knob_ff <= req_tdata[KnobWidth:1];
         cnt_ff  <= tick_ff + 1'b1;
         rem_ff  <= '0;
         quo_ff  <= {bps_ff, 16'h0000};
      end else if (cmd.div_step) begin
         rem_ff  <= q_bit ? rem_shift - {1'b0, cnt_ff} : rem_shift;
         quo_ff  <= {quo_ff[30:0], q_bit};
      end
   end

   assign accept   = tapping_ff && tap_ff && (cnt_ff > min_ff);
   assign new_freq = (quo_ff[31:24] != 8'h00) ? FreqMax : quo_ff[FreqWidth-1:0];
   assign mix      = 32'(WeightOld * freq_ff) + 32'(WeightNew * new_freq);

   always_comb begin
      tick_in      = tick_ff;
      tapping_in   = tapping_ff;
      averaging_in = averaging_ff;
      mode_in      = mode_ff;
      freq_in      = freq_ff;
      last_knob_in = last_knob_ff;
      if (tapping_ff) begin
         tick_in = cnt_ff;
         if (accept) begin
            freq_in      = averaging_ff ? mix[31:8] : new_freq;
            averaging_in = 1'b1;
            mode_in      = 1'b1;
            tick_in      = '0;
         end else if (cnt_ff == max_ff) begin
            tick_in      = '0;
            tapping_in   = 1'b0;
            averaging_in = 1'b0;
         end
      end else if (tap_ff) begin
         tapping_in = 1'b1;
      end
      diff = (knob_ff > last_knob_ff) ? {1'b0, knob_ff} - {1'b0, last_knob_ff}
                                      : {1'b0, last_knob_ff} - {1'b0, knob_ff};
      if (!mode_in) begin
         last_knob_in = knob_ff;
      end else if (diff > {1'b0, deadband_ff}) begin
         mode_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         tapping_ff   <= 1'b0;
         averaging_ff <= 1'b0;
         mode_ff      <= 1'b0;
         freq_ff      <= '0;
         last_knob_ff <= '0;
      end else if (cmd.commit) begin
         tick_ff      <= tick_in;
         tapping_ff   <= tapping_in;
         averaging_ff <= averaging_in;
         mode_ff      <= mode_in;
         freq_ff      <= freq_in;
         last_knob_ff <= last_knob_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {5'b00000, accept, tapping_in, mode_in, freq_in};
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.need_div = accept;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

// File: src/tap_tempo_estimator_core.sv
// Top level of the tap tempo estimator: controller plus datapath.
// Depends on tte_pkg, tte_ctrl and tte_datapath.
//
//  channel  dir  ports                       payload
//  req      in   req_tvalid/tready/tdata     tap_edge, knob_pos
//  rsp      out  rsp_tvalid/tready/tdata     tap_freq, use_tap, is_tapping, new_tempo
//  csr      in   csr_we/addr/wdata           four settings, index 0..3
//
// A tick goes through accept, evaluate and finish, with a 32-step restoring divider in between when a tap is accepted.
// One tick at a time; the next is taken while the previous result waits in rsp.
// The result is committed only once the output register is free.
// Synchronous reset restores the settings and clears all tempo state.
module tap_tempo_estimator_core import tte_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [CfgWidth-1:0] csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // tap_edge, knob_pos[11:0], pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata    // tap_freq[23:0], use_tap, is_tapping, new_tempo, pad
);

   cmd_type    cmd;
   status_type status;

   tte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tte_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result committed over a pending transfer");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a tick is in progress");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_tready && !cmd.commit)
      else $error("divider step overlaps accept or commit");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for tap_tempo_estimator_core: streams block ticks, predicts every
// result in-house and checks each rsp transfer field by field.
// Depends on tte_pkg and the tap_tempo_estimator_core RTL.
module testbench;
   import tte_pkg::*;

   typedef struct packed {
      logic [11:0] knob;
      logic        tap;
   } tick_t;

   typedef struct packed {
      logic [4:0]  pad;
      logic        new_tempo;
      logic        is_tapping;
      logic        use_tap;
      logic [23:0] freq;
   } result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   tick_t   tick_queue[$];
   result_t tempo_expected[$];

   // predictor copy of settings and tempo state
   logic [15:0] cfg_bps = ResetBlocksPerSecond;
   logic [15:0] cfg_min = ResetMinCount;
   logic [15:0] cfg_max = ResetMaxCount;
   logic [11:0] cfg_deadband = ResetKnobDeadband;
   logic [15:0] tp_count = '0;
   logic        tp_tapping = 1'b0;
   logic        tp_averaging = 1'b0;
   logic        tp_mode = 1'b0;
   logic [23:0] tp_freq = '0;
   logic [11:0] tp_knob = '0;

   int  errors = 0;
   bit  idle_on = 1'b1;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  results_seen = 0;
   longint cycles = 0;

   tap_tempo_estimator_core DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic result_t tempo_predict(tick_t t);
      logic [39:0] quo;
      logic [39:0] mix;
      logic [23:0] nf;
      logic [11:0] diff;
      result_t r;
      r = '0;
      if (tp_tapping) begin
         tp_count = tp_count + 16'd1;
         if (t.tap && tp_count > cfg_min) begin
            quo = (tp_count == 16'd0) ? 40'hFFFFFF : {8'b0, cfg_bps, 16'b0} / tp_count;
            nf = (quo > FreqMax) ? FreqMax : quo[23:0];
            if (tp_averaging) begin
               mix = WeightOld * tp_freq + WeightNew * nf;
               tp_freq = mix[31:8];
            end else begin
               tp_freq = nf;
               tp_averaging = 1'b1;
            end
            tp_mode = 1'b1;
            tp_count = '0;
            r.new_tempo = 1'b1;
         end else if (tp_count == cfg_max) begin
            tp_count = '0;
            tp_tapping = 1'b0;
            tp_averaging = 1'b0;
         end
      end else if (t.tap) begin
         tp_tapping = 1'b1;
      end
      if (!tp_mode) begin
         tp_knob = t.knob;
      end else begin
         diff = (t.knob > tp_knob) ? t.knob - tp_knob : tp_knob - t.knob;
         if (diff > cfg_deadband) tp_mode = 1'b0;
      end
      r.freq = tp_freq;
      r.use_tap = tp_mode;
      r.is_tapping = tp_tapping;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // request driver
   always @(posedge clock) begin
      tick_t t;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tempo_expected.push_back(tempo_predict(tick_t'(req_tdata[12:0])));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               t = tick_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {3'b0, t.knob, t.tap};
               send_gap = idle_on ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      result_t got;
      result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen = results_seen + 1;
            if (results_seen == 100 || results_seen == 700) hold_left = 400;
            if (tempo_expected.size() == 0) begin
               $error("unexpected result transfer: %h", rsp_tdata);
               errors = errors + 1;
            end else begin
               want = tempo_expected.pop_front();
               if (got.freq !== want.freq) begin
                  $error("tap_freq mismatch: expected %0d, actual %0d", want.freq, got.freq);
                  errors = errors + 1;
               end
               if (got.use_tap !== want.use_tap) begin
                  $error("use_tap mismatch: expected %0d, actual %0d",
                         want.use_tap, got.use_tap);
                  errors = errors + 1;
               end
               if (got.is_tapping !== want.is_tapping) begin
                  $error("is_tapping mismatch: expected %0d, actual %0d",
                         want.is_tapping, got.is_tapping);
                  errors = errors + 1;
               end
               if (got.new_tempo !== want.new_tempo) begin
                  $error("new_tempo mismatch: expected %0d, actual %0d",
                         want.new_tempo, got.new_tempo);
                  errors = errors + 1;
               end
               if (got.pad !== want.pad) begin
                  $error("pad mismatch: expected %0d, actual %0d", want.pad, got.pad);
                  errors = errors + 1;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on) stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
         end
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > 2000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_tick(bit tap, int knob);
      tick_t t;
      t.tap = tap;
      t.knob = knob[11:0];
      tick_queue.push_back(t);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BLOCKS_PER_SECOND: cfg_bps = val;
         CSR_MIN_COUNT:         cfg_min = val;
         CSR_MAX_COUNT:         cfg_max = val;
         CSR_KNOB_DEADBAND:     cfg_deadband = val[11:0];
      endcase
   endtask

   task automatic set_config(int bps, int mn, int mx, int db);
      write_reg(CSR_BLOCKS_PER_SECOND, bps[15:0]);
      write_reg(CSR_MIN_COUNT, mn[15:0]);
      write_reg(CSR_MAX_COUNT, mx[15:0]);
      write_reg(CSR_KNOB_DEADBAND, db[15:0]);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (tick_queue.size() > 0 || req_tvalid || tempo_expected.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic int near_knob(int base, int db);
      int off;
      int v;
      off = $urandom_range(0, db / 2);
      v = $urandom_range(0, 1) ? base + off : base - off;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   initial begin
      int bps, mn, mx, db;
      int base, g, n, r, ntaps;
      bit jump;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: arm, extremes of the knob, a tap that comes too early
      push_tick(0, 0);
      push_tick(1, 4095);
      push_tick(0, 4095);
      push_tick(1, 0);
      push_tick(0, 2048);
      wait_drained();

      // saturated division, first and blended taps, zero deadband
      set_config(65535, 0, 65535, 0);
      push_tick(1, 100);
      push_tick(1, 100);
      push_tick(1, 100);
      push_tick(1, 100);
      push_tick(0, 101);
      wait_drained();

      // smallest rate, max count reached, wide deadband
      set_config(1, 2, 3, 4095);
      push_tick(1, 0);
      push_tick(0, 4095);
      push_tick(1, 4095);
      push_tick(0, 0);
      push_tick(0, 0);
      push_tick(1, 0);
      push_tick(0, 4095);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               bps = 65535; mn = 0; mx = $urandom_range(1, 8); db = 0;
            end
            1: begin
               bps = 1; mn = $urandom_range(0, 10); mx = mn + $urandom_range(2, 40); db = 4095;
            end
            default: begin
               bps = $urandom_range(1, 65535);
               mn = $urandom_range(0, 30);
               mx = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60)
                                                : mn + $urandom_range(2, 60);
               db = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, 300);
            end
         endcase
         set_config(bps, mn, mx, db);
         idle_on = (ph != 3);
         n = 0;
         while (n < 180) begin
            base = $urandom_range(0, 4095);
            push_tick(1, near_knob(base, db));
            n++;
            ntaps = $urandom_range(1, 6);
            for (int k = 0; k < ntaps; k++) begin
               r = $urandom_range(0, 9);
               jump = (r == 9);
               if (r == 7) g = (mn > 0) ? $urandom_range(1, mn) : 1;
               else if (r == 8) g = mx + $urandom_range(0, 3);
               else if (mx > mn + 1) g = $urandom_range(mn + 1, mx - 1);
               else g = $urandom_range(1, mx + 2);
               for (int i = 1; i < g; i++) begin
                  if (jump && i == g / 2) push_tick(0, $urandom_range(0, 4095));
                  else push_tick($urandom_range(0, 32) == 0, near_knob(base, db));
               end
               push_tick(1, near_knob(base, db));
               n += g;
            end
            r = $urandom_range(0, 5);
            for (int i = 0; i < r; i++) push_tick(0, $urandom_range(0, 4095));
            n += r;
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
